// ===== design/fnvhm_pkg.sv =====
// Package for the FNV-1a chained hash map unit.
// Types, constants and byte-count helpers shared by the design files but fnvhm_ram.
package fnvhm_pkg;
    localparam int BUCKETS = 64;
    localparam int ENTRIES = 64;
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = EW + 1;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [PW-1:0] NIL_SLOT = PW'(ENTRIES);
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0, OP_UPDATE = 2'd1, OP_DELETE = 2'd2, OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_DISABLED = 2'd3
    } t_status;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_KEY_BYTES = 2'd1;
    localparam logic [1:0] REG_VAL_BYTES = 2'd2;
    localparam logic [1:0] REG_ENTRY_LIMIT = 2'd3;

    // Classified request handed from front to back.
    typedef struct packed {
        t_op         op;
        logic        enabled;
        logic [BW-1:0] bucket;
        logic [63:0] key;
        logic [63:0] kmask;
        logic [63:0] value;
        logic [63:0] vmask;
        logic [6:0]  limit;
    } t_req;

    function automatic logic [3:0] clamp_bytes(input logic [3:0] n);
        logic [3:0] r;
        r = n;
        if (n == 4'd0) r = 4'd1;
        else if (n > 4'd8) r = 4'd8;
        return r;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        return m;
    endfunction
endpackage

// ===== design/fnvhm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module fnvhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/fnvhm_front.sv =====
// Front end: accepts requests, hashes the key one byte a cycle.
// Depends on fnvhm_pkg.
module fnvhm_front import fnvhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    input  logic        i_enable,
    input  logic [3:0]  i_key_bytes,
    input  logic [3:0]  i_val_bytes,
    input  logic [6:0]  i_entry_limit,
    output logic        o_valid,
    input  logic        i_ready,
    output t_req        o_req
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_nb;
    logic [31:0] r_h, n_h;
    t_req        r_req;
    logic [31:0] w_mix;

    assign o_ready = !r_busy;
    assign o_valid = r_done;
    assign o_req   = '{op: r_req.op, enabled: r_req.enabled, bucket: r_h[BW-1:0],
                       key: r_req.key, kmask: r_req.kmask, value: r_req.value,
                       vmask: r_req.vmask, limit: r_req.limit};
    assign w_mix   = (r_h ^ {24'd0, r_req.key[{r_idx[2:0], 3'b000} +: 8]}) * FNV_PRIME;

    always_comb begin
        n_busy = r_busy; n_done = r_done; n_idx = r_idx; n_h = r_h;
        if (i_valid && o_ready) begin
            n_busy = 1'b1; n_done = 1'b0; n_idx = 4'd0; n_h = FNV_BASIS;
        end else if (r_busy && !r_done) begin
            // Skip hashing where the key is not looked at.
            if (r_req.op == OP_CLEAR || !r_req.enabled || r_idx == r_nb) n_done = 1'b1;
            else begin
                n_h = w_mix; n_idx = r_idx + 4'd1;
            end
        end else if (r_done && i_ready) begin
            n_busy = 1'b0; n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_idx <= n_idx; r_h <= n_h;
        if (i_valid && o_ready) begin
            r_nb          <= clamp_bytes(i_key_bytes);
            r_req.op      <= t_op'(i_op);
            r_req.enabled <= i_enable;
            r_req.bucket  <= '0;
            r_req.key     <= i_key;
            r_req.kmask   <= byte_mask(clamp_bytes(i_key_bytes));
            r_req.value   <= i_value;
            r_req.vmask   <= byte_mask(clamp_bytes(i_val_bytes));
            r_req.limit   <= (i_entry_limit > 7'(ENTRIES)) ? 7'(ENTRIES) : i_entry_limit;
        end
    end

`ifndef SYNTH
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_busy) else $error("done without busy");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= 4'd8) else $error("hash index overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !i_ready |=> r_done) else $error("request dropped");
`endif
endmodule

// ===== design/fnvhm_queue.sv =====
// Short request queue between front and back end.
// Depends on fnvhm_pkg.
module fnvhm_queue import fnvhm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_req o_req
);
    t_req r_q [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != 2'(QDEPTH);
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_q[r_wp] <= i_req;
    end

`ifndef SYNTH
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue count overrun");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'(QDEPTH)) |-> r_wp == r_rp) else $error("pointer skew");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QDEPTH) && !w_pop |=> !o_ready) else $error("queue full lost");
`endif
endmodule

// ===== design/fnvhm_back.sv =====
// Back end: walks the bucket chain in entry memory and applies the request.
// Depends on fnvhm_pkg and fnvhm_ram.
module fnvhm_back import fnvhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_value,
    output logic [6:0]  o_count
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HEAD  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_VAL   = 8'b0001_0000,
        S_FREE  = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_st, n_st;
    t_req   r_req;
    logic [BUCKETS-1:0] r_hvalid;
    logic [PW-1:0] r_cur, r_prev, r_nxt;
    logic [6:0]    r_steps;
    logic          r_found;
    logic [6:0]    r_live;
    logic [PW-1:0] r_ftop;
    logic [ENTRIES-1:0] r_fvalid;   // free-stack positions written since clear
    logic [1:0]    r_status;
    logic [63:0]   r_vout;
    logic [EW-1:0] r_slot;

    // Memories
    logic          w_hwe;  logic [BW-1:0] w_hwa, w_hra; logic [PW-1:0] w_hwd, w_hrd;
    logic          w_kwe;  logic [EW-1:0] w_kwa, w_kra; logic [63:0] w_kwd, w_krd;
    logic          w_vwe;  logic [63:0] w_vwd, w_vrd;
    logic          w_nwe;  logic [EW-1:0] w_nwa; logic [PW-1:0] w_nwd, w_nrd;
    logic          w_fwe;  logic [EW-1:0] w_fwa, w_fra; logic [EW-1:0] w_fwd, w_frd;
    logic [PW-1:0] w_head;
    logic [EW-1:0] w_fidx;

    fnvhm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (.i_clk, .i_we(w_hwe), .i_waddr(w_hwa),
        .i_wdata(w_hwd), .i_raddr(w_hra), .o_rdata(w_hrd));
    fnvhm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key (.i_clk, .i_we(w_kwe), .i_waddr(w_kwa),
        .i_wdata(w_kwd), .i_raddr(w_kra), .o_rdata(w_krd));
    fnvhm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_val (.i_clk, .i_we(w_vwe), .i_waddr(w_kwa),
        .i_wdata(w_vwd), .i_raddr(w_kra), .o_rdata(w_vrd));
    fnvhm_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_next (.i_clk, .i_we(w_nwe), .i_waddr(w_nwa),
        .i_wdata(w_nwd), .i_raddr(w_kra), .o_rdata(w_nrd));
    fnvhm_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (.i_clk, .i_we(w_fwe), .i_waddr(w_fwa),
        .i_wdata(w_fwd), .i_raddr(w_fra), .o_rdata(w_frd));

    assign o_ready  = r_st == S_IDLE;
    assign o_valid  = r_st == S_OUT;
    assign o_status = r_status;
    assign o_value  = r_vout;
    assign o_count  = r_live;
    assign w_head   = r_hvalid[r_req.bucket] ? w_hrd : NIL_SLOT;
    assign w_fidx   = EW'(r_ftop - PW'(1));
    assign w_hra    = i_req.bucket;
    assign w_kra    = r_cur[EW-1:0];
    assign w_fra    = w_fidx;

    always_comb begin
        n_st = r_st;
        w_hwe = 1'b0; w_hwa = r_req.bucket; w_hwd = NIL_SLOT;
        w_kwe = 1'b0; w_kwa = r_slot; w_kwd = r_req.key;
        w_vwe = 1'b0; w_vwd = r_req.value & r_req.vmask;
        w_nwe = 1'b0; w_nwa = r_prev[EW-1:0]; w_nwd = r_nxt;
        w_fwe = 1'b0; w_fwa = r_ftop[EW-1:0]; w_fwd = r_cur[EW-1:0];
        case (r_st)
            S_IDLE: if (i_valid) begin
                if (i_req.op == OP_CLEAR || !i_req.enabled) n_st = S_OUT;
                else n_st = S_HEAD;
            end
            S_HEAD: n_st = (w_head == NIL_SLOT) ? S_VAL : S_READ;
            S_READ: n_st = S_CMP;
            S_CMP: begin
                if (((w_krd ^ r_req.key) & r_req.kmask) == 64'd0) n_st = S_VAL;
                else if (w_nrd == NIL_SLOT || r_steps == 7'(ENTRIES - 1)) n_st = S_VAL;
                else n_st = S_READ;
            end
            S_VAL: n_st = (r_req.op == OP_UPDATE && !r_found) ? S_FREE : S_WR;
            S_FREE: n_st = S_WR;
            S_WR: begin
                n_st = S_OUT;
                if (r_status == ST_OK) begin
                    case (r_req.op)
                        OP_UPDATE: begin
                            if (r_found) begin
                                w_vwe = 1'b1; w_kwa = r_cur[EW-1:0];
                            end else begin
                                w_kwe = 1'b1; w_vwe = 1'b1;
                                w_nwe = 1'b1; w_nwa = r_slot; w_nwd = r_nxt;
                                w_hwe = 1'b1; w_hwd = {1'b0, r_slot};
                            end
                        end
                        OP_DELETE: begin
                            if (r_prev != NIL_SLOT) w_nwe = 1'b1;
                            else begin
                                w_hwe = 1'b1; w_hwd = r_nxt;
                            end
                            w_fwe = r_ftop < PW'(ENTRIES);
                        end
                        default: ;
                    endcase
                end
            end
            S_OUT: if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_hvalid <= '0; r_live <= 7'd0;
            r_ftop <= PW'(ENTRIES); r_fvalid <= '0;
        end else begin
            r_st <= n_st;
            if (w_hwe) r_hvalid[r_req.bucket] <= 1'b1;
            if (w_fwe) r_fvalid[w_fwa] <= 1'b1;
            if (r_st == S_IDLE && i_valid && i_req.op == OP_CLEAR) begin
                r_hvalid <= '0; r_live <= 7'd0; r_ftop <= PW'(ENTRIES); r_fvalid <= '0;
            end
            if (r_st == S_WR && r_status == ST_OK) begin
                if (r_req.op == OP_UPDATE && !r_found) begin
                    r_live <= r_live + 7'd1; r_ftop <= r_ftop - PW'(1);
                end else if (r_req.op == OP_DELETE) begin
                    if (r_live != 7'd0) r_live <= r_live - 7'd1;
                    if (r_ftop < PW'(ENTRIES)) r_ftop <= r_ftop + PW'(1);
                end
            end
        end
        case (r_st)
            S_IDLE: if (i_valid) begin
                r_req <= i_req; r_found <= 1'b0; r_prev <= NIL_SLOT; r_steps <= 7'd0;
                r_vout <= 64'd0;
                r_status <= (i_req.op != OP_CLEAR && !i_req.enabled) ? ST_DISABLED : ST_OK;
            end
            S_HEAD: begin
                r_cur <= w_head; r_nxt <= w_head;
            end
            S_CMP: begin
                if (((w_krd ^ r_req.key) & r_req.kmask) == 64'd0) begin
                    r_found <= 1'b1; r_nxt <= w_nrd;
                end else begin
                    r_prev <= r_cur; r_cur <= w_nrd; r_steps <= r_steps + 7'd1;
                end
            end
            S_VAL: begin
                // Status and lookup value; r_nxt keeps the old head for insert.
                if (r_req.op == OP_LOOKUP) begin
                    if (r_found) r_vout <= w_vrd & r_req.vmask;
                    else r_status <= ST_NOT_FOUND;
                end else if (r_req.op == OP_DELETE) begin
                    if (!r_found) r_status <= ST_NOT_FOUND;
                end else if (!r_found) begin
                    if (r_live >= r_req.limit || r_ftop == '0) r_status <= ST_FULL;
                    if (!r_hvalid[r_req.bucket]) r_nxt <= NIL_SLOT;
                end
            end
            // Unwritten stack positions hold their own index.
            S_FREE: r_slot <= r_fvalid[w_fidx] ? w_frd : w_fidx;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    a_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= 7'(ENTRIES)) else $error("live count overrun");
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> 7'(r_ftop) + r_live == 7'(ENTRIES)) else $error("free stack skew");
`endif
endmodule

// ===== design/fnv_chained_hash_map_unit.sv =====
// Top level of the FNV-1a chained hash map unit.
// Depends on fnvhm_pkg, fnvhm_front, fnvhm_queue, fnvhm_back.
//
// channel    direction  fields
// s_axis     in         tuser op, tdata {value, key}
// m_axis     out        tdata {entry_count, value_out, status}
// apb        in/out     map_enable, key_bytes, val_bytes, entry_limit
//
// The front hashes one key byte a cycle, none for clear or a disabled map. The back
// goes straight to output for clear or a disabled map, else reads the bucket head,
// then reads and compares each chain entry in turn through the registered read of
// the entry memories, sets the status, reads the free stack for an insert, writes
// and outputs; the two overlap through the queue. Reset empties the map at once through
// per-bucket and per-free-stack-position valid bits; no clearing pass.
// Either side stalls on its own.
module fnv_chained_hash_map_unit import fnvhm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key[63:0], value[127:64]
    input  logic [1:0]   s_axis_tuser,   // op[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // status[1:0], value_out[65:2], entry_count[72:66]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic       r_enable;
    logic [3:0] r_key_bytes, r_val_bytes;
    logic [6:0] r_entry_limit;
    logic       w_fvalid, w_fready, w_qvalid, w_qready;
    t_req       w_freq, w_qreq;
    logic [1:0] w_status;
    logic [63:0] w_value;
    logic [6:0] w_count;

    assign pready = 1'b1;

    // Take register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0; r_key_bytes <= 4'd4; r_val_bytes <= 4'd8;
            r_entry_limit <= 7'd64;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ENABLE:      r_enable <= pwdata[0];
                REG_KEY_BYTES:   r_key_bytes <= pwdata[3:0];
                REG_VAL_BYTES:   r_val_bytes <= pwdata[3:0];
                REG_ENTRY_LIMIT: r_entry_limit <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE:      prdata = {31'd0, r_enable};
            REG_KEY_BYTES:   prdata = {28'd0, r_key_bytes};
            REG_VAL_BYTES:   prdata = {28'd0, r_val_bytes};
            REG_ENTRY_LIMIT: prdata = {25'd0, r_entry_limit};
            default:         prdata = 32'd0;
        endcase
    end

    fnvhm_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_key(s_axis_tdata[63:0]), .i_value(s_axis_tdata[127:64]),
        .i_enable(r_enable), .i_key_bytes(r_key_bytes), .i_val_bytes(r_val_bytes),
        .i_entry_limit(r_entry_limit), .o_valid(w_fvalid), .i_ready(w_fready),
        .o_req(w_freq));

    fnvhm_queue u_queue (.i_clk, .i_rst_n, .i_valid(w_fvalid), .o_ready(w_fready),
        .i_req(w_freq), .o_valid(w_qvalid), .i_ready(w_qready), .o_req(w_qreq));

    fnvhm_back u_back (.i_clk, .i_rst_n, .i_valid(w_qvalid), .o_ready(w_qready),
        .i_req(w_qreq), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_value(w_value), .o_count(w_count));

    assign m_axis_tdata = {7'd0, w_count, w_value, w_status};
endmodule
